### hw/rtl/kbl_pkg.sv
// Shared types and constants for the keyed clipped rectangle blitter.
// No dependencies; used by every other file of the block.
`default_nettype none

package kbl_pkg;

  localparam int COORD_BITS   = 16;  // coordinate register width (8..16)
  localparam int CNT_BITS     = 16;  // column / row counter width
  localparam int TGT_BITS     = CNT_BITS + 2;  // signed target coordinate
  localparam int COLOR_BITS   = 32;
  localparam int ADDR_BITS    = 32;
  localparam int OP_BITS      = 2;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  typedef enum logic [OP_BITS-1:0] {
    OP_COPY    = 2'd0,
    OP_STENCIL = 2'd1,
    OP_FILL    = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ORIGIN_X       = 3'd0,
    REG_ORIGIN_Y       = 3'd1,
    REG_RECT_WIDTH     = 3'd2,
    REG_RECT_HEIGHT    = 3'd3,
    REG_SURFACE_WIDTH  = 3'd4,
    REG_SURFACE_HEIGHT = 3'd5,
    REG_KEY_COLOR      = 3'd6,
    REG_FILL_COLOR     = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] origin_x;  // two's complement
    logic [COORD_BITS-1:0] origin_y;  // two's complement
    logic [COORD_BITS-1:0] rect_width;
    logic [COORD_BITS-1:0] rect_height;
    logic [COORD_BITS-1:0] surface_width;
    logic [COORD_BITS-1:0] surface_height;
    logic [COLOR_BITS-1:0] key_color;
    logic [COLOR_BITS-1:0] fill_color;
  } cfg_t;

  // Decided pixel, waiting for its address to be formed.
  typedef struct packed {
    logic                  wr;
    logic [CNT_BITS-1:0]   tx;
    logic [CNT_BITS-1:0]   ty;
    logic [COLOR_BITS-1:0] data;
    logic                  last;
  } pix_t;

endpackage

`default_nettype wire

### hw/rtl/kbl_ifs.sv
// Channel interfaces: pixel in, framebuffer write out, register write.
// Depends on kbl_pkg.
`default_nettype none

interface kbl_pix_if;
  logic                                valid;
  logic                                ready;
  logic [kbl_pkg::OP_BITS-1:0]         op;
  logic                                first;
  logic [kbl_pkg::COLOR_BITS-1:0]      pixel;
  modport source(output valid, op, first, pixel, input ready);
  modport sink(input valid, op, first, pixel, output ready);
endinterface

interface kbl_wr_if;
  logic                                valid;
  logic                                ready;
  logic                                write_enable;
  logic [kbl_pkg::ADDR_BITS-1:0]       write_address;
  logic [kbl_pkg::COLOR_BITS-1:0]      write_data;
  logic                                last;
  modport source(output valid, write_enable, write_address, write_data, last, input ready);
  modport sink(input valid, write_enable, write_address, write_data, last, output ready);
endinterface

interface kbl_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [kbl_pkg::CFG_IDX_BITS-1:0]    index;
  logic [kbl_pkg::CFG_DATA_BITS-1:0]   data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/kbl_cfg_regs.sv
// Configuration register file, written through the register channel.
// Depends on kbl_pkg and kbl_ifs.
`default_nettype none

module kbl_cfg_regs (
  input  wire logic    clk,
  input  wire logic    rst,
  kbl_cfg_if.sink      cfg,
  output kbl_pkg::cfg_t regs
);

  kbl_pkg::cfg_t regs_next;
  logic [kbl_pkg::COORD_BITS-1:0] coord;

  assign cfg.ready = 1'b1;
  assign coord = cfg.data[kbl_pkg::COORD_BITS-1:0];

  always_comb begin
    regs_next = regs;
    if (cfg.valid) begin
      unique case (kbl_pkg::cfg_reg_t'(cfg.index))
        kbl_pkg::REG_ORIGIN_X:       regs_next.origin_x = coord;
        kbl_pkg::REG_ORIGIN_Y:       regs_next.origin_y = coord;
        kbl_pkg::REG_RECT_WIDTH:     regs_next.rect_width = coord;
        kbl_pkg::REG_RECT_HEIGHT:    regs_next.rect_height = coord;
        kbl_pkg::REG_SURFACE_WIDTH:  regs_next.surface_width = coord;
        kbl_pkg::REG_SURFACE_HEIGHT: regs_next.surface_height = coord;
        kbl_pkg::REG_KEY_COLOR:      regs_next.key_color = cfg.data[kbl_pkg::COLOR_BITS-1:0];
        kbl_pkg::REG_FILL_COLOR:     regs_next.fill_color = cfg.data[kbl_pkg::COLOR_BITS-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.origin_x       <= '0;
      regs.origin_y       <= '0;
      regs.rect_width     <= kbl_pkg::COORD_BITS'(1);
      regs.rect_height    <= kbl_pkg::COORD_BITS'(1);
      regs.surface_width  <= kbl_pkg::COORD_BITS'(1);
      regs.surface_height <= kbl_pkg::COORD_BITS'(1);
      regs.key_color      <= '0;
      regs.fill_color     <= '0;
    end else begin
      regs <= regs_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/kbl_pos_stage.sv
// Raster position counters, clip test and color-key decision.
// Registers one decided pixel per accepted word. Depends on kbl_pkg.
`default_nettype none

module kbl_pos_stage (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire kbl_pkg::cfg_t                  regs,
  input  wire logic                           take,
  input  wire logic [kbl_pkg::OP_BITS-1:0]    op,
  input  wire logic                           first,
  input  wire logic [kbl_pkg::COLOR_BITS-1:0] pixel,
  input  wire logic                           adv,
  output kbl_pkg::pix_t                       pix,
  output logic                                pix_valid
);

  localparam int CB = kbl_pkg::CNT_BITS;
  localparam int TB = kbl_pkg::TGT_BITS;

  logic [CB-1:0] column_count, column_count_next;
  logic [CB-1:0] row_count, row_count_next;
  logic [CB-1:0] col, row;
  logic          col_end, row_end, hit, key_wr;
  logic [TB-1:0] tx, ty;
  logic [kbl_pkg::COLOR_BITS-1:0] data;
  kbl_pkg::pix_t pix_next;

  always_comb begin
    col = first ? '0 : column_count;
    row = first ? '0 : row_count;
    // a counter at or past its bound ends the row or column
    col_end = ({1'b0, col} + (CB+1)'(1)) >= (CB+1)'(regs.rect_width);
    row_end = ({1'b0, row} + (CB+1)'(1)) >= (CB+1)'(regs.rect_height);

    tx = TB'(signed'(regs.origin_x)) + TB'(col);
    ty = TB'(signed'(regs.origin_y)) + TB'(row);
    // negative targets have the top bit set and fail the unsigned compare
    hit = (tx < TB'(regs.surface_width)) && (ty < TB'(regs.surface_height));

    unique case (op)
      kbl_pkg::OP_COPY: begin
        key_wr = pixel != regs.key_color;
        data   = pixel;
      end
      kbl_pkg::OP_STENCIL: begin
        key_wr = pixel != regs.key_color;
        data   = regs.fill_color;
      end
      kbl_pkg::OP_FILL: begin
        key_wr = regs.fill_color != regs.key_color;
        data   = regs.fill_color;
      end
      default: begin
        key_wr = 1'b0;
        data   = '0;
      end
    endcase

    pix_next.wr   = key_wr && hit;
    pix_next.tx   = tx[CB-1:0];
    pix_next.ty   = ty[CB-1:0];
    pix_next.data = pix_next.wr ? data : '0;
    pix_next.last = col_end && row_end;

    if (col_end) begin
      column_count_next = '0;
      row_count_next    = row_end ? '0 : row + CB'(1);
    end else begin
      column_count_next = col + CB'(1);
      row_count_next    = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      pix_valid    <= 1'b0;
    end else begin
      if (take) begin
        column_count <= column_count_next;
        row_count    <= row_count_next;
        pix_valid    <= 1'b1;
      end else if (adv) begin
        pix_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pix <= pix_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/kbl_addr_stage.sv
// Row-major address multiply-add and the output register.
// Depends on kbl_pkg and kbl_ifs.
`default_nettype none

module kbl_addr_stage (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [kbl_pkg::COORD_BITS-1:0] surface_width,
  input  wire kbl_pkg::pix_t                  pix,
  input  wire logic                           pix_valid,
  output logic                                adv,
  kbl_wr_if.source                            dst
);

  localparam int AB = kbl_pkg::ADDR_BITS;
  localparam int PB = kbl_pkg::CNT_BITS + kbl_pkg::COORD_BITS;

  logic [PB-1:0] prod;
  logic [AB-1:0] addr;

  assign adv  = pix_valid && (!dst.valid || dst.ready);
  assign prod = PB'(pix.ty) * PB'(surface_width);
  assign addr = pix.wr ? (AB'(prod) + AB'(pix.tx)) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      dst.valid <= 1'b0;
    end else if (adv) begin
      dst.valid <= 1'b1;
    end else if (dst.ready) begin
      dst.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dst.write_enable  <= pix.wr;
      dst.write_address <= addr;
      dst.write_data    <= pix.data;
      dst.last          <= pix.last;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/keyed_clipped_rect_blitter.sv
// Color-keyed rectangle blitter with surface clipping, one pixel word per cycle while the write channel is not stalled.
// The decided pixel is registered in the position stage, then the write in the address stage's output register.
// Throughput: 1 word per cycle unless dst.ready stalls the output; the 16x16 address multiply has its own stage.
// Reset: counters to the top-left pixel, registers to their defaults, pipeline empty.
// The register port is always ready. Depends on kbl_pkg, kbl_ifs and the kbl_* stages.
`default_nettype none

module keyed_clipped_rect_blitter (
  input  wire logic clk,
  input  wire logic rst,
  kbl_pix_if.sink   src,
  kbl_wr_if.source  dst,
  kbl_cfg_if.sink   cfg
);

  kbl_pkg::cfg_t regs;
  kbl_pkg::pix_t pix;
  logic          pix_valid;
  logic          adv;
  logic          take;

  assign src.ready = !pix_valid || adv;
  assign take      = src.valid && src.ready;

  kbl_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  kbl_pos_stage u_pos (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .take      (take),
    .op        (src.op),
    .first     (src.first),
    .pixel     (src.pixel),
    .adv       (adv),
    .pix       (pix),
    .pix_valid (pix_valid)
  );

  kbl_addr_stage u_addr (
    .clk           (clk),
    .rst           (rst),
    .surface_width (regs.surface_width),
    .pix           (pix),
    .pix_valid     (pix_valid),
    .adv           (adv),
    .dst           (dst)
  );

endmodule

`default_nettype wire
